// ===== hdl/integer_to_ascii_formatter_core_macros.svh =====
// Assertion macros for the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ITOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ITOA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/itoa_pkg.sv =====
// Types, constants and helper functions for the integer-to-ASCII formatter.
package itoa_pkg;

  localparam int VALUE_W   = 64;
  localparam int HALF_W    = 32;
  localparam int DIGIT_W   = 4;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
  localparam int POS_W     = 5;
  localparam int STEP_W    = 7;
  localparam int STEPS32   = HALF_W;
  localparam int STEPS64   = VALUE_W;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] DEC_BASE   = 4'd10;

  // Format selector codes.
  typedef enum logic [1:0] {
    OP_S32   = 2'd0,
    OP_U32   = 2'd1,
    OP_S64   = 2'd2,
    OP_HEX64 = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the digit register.
  typedef struct packed {
    logic load;
    logic step;
    logic shift_out;
  } dig_cmd_t;

  // ASCII character for one decimal or hexadecimal digit.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DEC_BASE) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d - DEC_BASE};
    end
    return c;
  endfunction

endpackage

// ===== hdl/itoa_digits.sv =====
// Bit-serial binary-to-BCD converter and digit shift register.
module itoa_digits (
  input  logic                           clk,
  input  itoa_pkg::dig_cmd_t             cmd,
  input  logic [1:0]                     op,
  input  logic [itoa_pkg::VALUE_W-1:0]   value,
  output logic [itoa_pkg::DIGIT_W-1:0]   top_digit
);
  import itoa_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic [HALF_W-1:0]  low;
  logic [HALF_W-1:0]  mag32;
  logic [VALUE_W-1:0] mag64;

  // Magnitudes of the signed inputs; the most negative value wraps to itself.
  assign low   = value[HALF_W-1:0];
  assign mag32 = low[HALF_W-1] ? (~low + 1'b1) : low;
  assign mag64 = value[VALUE_W-1] ? (~value + 1'b1) : value;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Load, convert one bit per cycle, or shift one digit out.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (op_t'(op))
        OP_S32: begin
          bin <= {mag32, {HALF_W{1'b0}}};
          bcd <= '0;
        end
        OP_U32: begin
          bin <= {low, {HALF_W{1'b0}}};
          bcd <= '0;
        end
        OP_S64: begin
          bin <= mag64;
          bcd <= '0;
        end
        OP_HEX64: begin
          bin <= '0;
          bcd <= {{(BCD_W-VALUE_W){1'b0}}, value};
        end
        default: begin
          bin <= '0;
          bcd <= '0;
        end
      endcase
    end else if (cmd.step) begin
      bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end else if (cmd.shift_out) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

endmodule

// ===== hdl/itoa_ctrl.sv =====
// Sequencer for conversion and character output, with the output register.
`include "integer_to_ascii_formatter_core_macros.svh"

module itoa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    op,
  input  logic [itoa_pkg::VALUE_W-1:0]  value,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,
  output logic                          m_tlast,
  output itoa_pkg::dig_cmd_t            cmd,
  input  logic [itoa_pkg::DIGIT_W-1:0]  top_digit
);
  import itoa_pkg::*;

  state_t             state, state_next;
  logic [STEP_W-1:0]  steps;
  logic [POS_W-1:0]   pos;
  logic               sign_pend;
  logic               seen;
  logic               slot_free;
  logic               lead_zero;
  logic               is_last;
  logic               digit_done;
  logic               load_char;
  logic               accept;

  // Digit bookkeeping for the emit phase.
  assign slot_free  = !m_tvalid || m_tready;
  assign is_last    = (pos == POS_W'(1));
  assign lead_zero  = (top_digit == '0) && !seen && !is_last;
  assign digit_done = (state == ST_EMIT) && !sign_pend && (slot_free || lead_zero);
  assign load_char  = (state == ST_EMIT) && slot_free && (sign_pend || !lead_zero);
  assign accept     = s_tvalid && s_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (op_t'(op) == OP_HEX64) ? ST_EMIT : ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (steps == STEP_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (digit_done && is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and digit register commands.
  always_comb begin
    s_tready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    cmd.shift_out = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_CONVERT: cmd.step = 1'b1;
      ST_EMIT:    cmd.shift_out = digit_done;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State, counters and the output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      steps     <= '0;
      pos       <= '0;
      sign_pend <= 1'b0;
      seen      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        steps     <= (op_t'(op) == OP_S64) ? STEP_W'(STEPS64) : STEP_W'(STEPS32);
        pos       <= POS_W'(NUM_DIGITS);
        seen      <= 1'b0;
        sign_pend <= ((op_t'(op) == OP_S32) && value[HALF_W-1]) ||
                     ((op_t'(op) == OP_S64) && value[VALUE_W-1]);
      end else if (state == ST_CONVERT) begin
        steps <= steps - 1'b1;
      end
      if (digit_done) begin
        pos <= pos - 1'b1;
        if (!lead_zero) begin
          seen <= 1'b1;
        end
      end
      if (load_char) begin
        m_tvalid <= 1'b1;
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_char) begin
      m_tdata <= sign_pend ? CHAR_MINUS : digit_char(top_digit);
      m_tlast <= !sign_pend && is_last;
    end
  end

  `ITOA_ASSERT(a_accept_leaves_idle, (accept |=> (state != ST_IDLE)), "input word did not start work")
  `ITOA_NEVER(a_pos_range, (pos > POS_W'(NUM_DIGITS)), "digit position out of range")
  `ITOA_ASSERT(a_sign_before_digits, (sign_pend |-> !seen), "digit emitted before minus sign")
  `ITOA_ASSERT(a_word_from_emit, ($rose(m_tvalid) |-> ($past(state) == ST_EMIT)), "output word outside emit")

endmodule

// ===== hdl/integer_to_ascii_formatter_core.sv =====
// Top level of the integer-to-ASCII formatter.
//
//   Channel   Direction  Signals                       Contents (low bit up)
//   s_*       in         s_tvalid s_tready s_tdata     tdata[63:0] value
//                        s_tuser                       tuser[1:0] operation
//   m_*       out        m_tvalid m_tready m_tdata     tdata[7:0] character
//                        m_tlast                       tlast = last character
//
// One number is loaded, then takes 32 bit steps of the serial binary-to-BCD
// converter for the 32-bit modes, 64 for signed 64-bit decimal and none for
// hex. Then come the minus sign of a negative number and 20 digit positions,
// at one per cycle unless m_tready stalls. A new word is taken once the last
// character is registered. Reset (rst, synchronous) returns the sequencer to
// idle and drops m_tvalid. A stall on m_tready holds the current character
// and pauses output; leading zeros are still skipped meanwhile.
module integer_to_ascii_formatter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // character
  output logic        m_tlast
);
  import itoa_pkg::*;

  dig_cmd_t           cmd;
  logic [DIGIT_W-1:0] top_digit;

  itoa_digits u_digits (
    .clk       (clk),
    .cmd       (cmd),
    .op        (s_tuser),
    .value     (s_tdata),
    .top_digit (top_digit)
  );

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .op        (s_tuser),
    .value     (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .top_digit (top_digit)
  );

endmodule

// ===== verif/integer_to_ascii_formatter_core_tb.sv =====
// Self-checking testbench for the integer-to-ASCII formatter core.
module integer_to_ascii_formatter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_WORDS = 450;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_WORD    = 150;
  localparam int HOLD_END     = 170;
  localparam int PAUSE_WORD   = 300;

  // One expected character word on the output stream.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_word_t;

  // One row of the directed table; an empty text means "ask the predictor".
  typedef struct {
    op_t         op;
    logic [63:0] value;
    string       text;
  } format_case_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = 64'd0;
  logic [1:0]  s_tuser  = OP_S32;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  char_word_t   expected_chars[$];
  format_case_t directed_cases[$];
  char_word_t   got_char;
  int           error_count   = 0;
  int           cycle_count   = 0;
  int           hold_requests = 0;
  int           holds_started = 0;
  int           hold_left     = 0;
  int           stall_left    = 0;
  int           mode_left     = 0;
  bit           choppy        = 1'b0;
  int           burst_left    = 0;

  integer_to_ascii_formatter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Text that one number should turn into, most significant character first.
  function automatic string render_number(input op_t op, input logic [63:0] raw);
    logic [63:0] magnitude;
    logic [63:0] radix;
    logic [31:0] low_half;
    logic [3:0]  digit;
    logic [7:0]  glyph;
    logic        negative;
    string       text;
    int          digits;
    negative = 1'b0;
    radix    = 64'd10;
    low_half = raw[31:0];
    text     = "";
    case (op)
      OP_S32: begin
        negative  = low_half[31];
        magnitude = {32'd0, low_half[31] ? (~low_half + 32'd1) : low_half};
      end
      OP_U32: begin
        magnitude = {32'd0, low_half};
      end
      OP_S64: begin
        negative  = raw[63];
        magnitude = raw[63] ? (~raw + 64'd1) : raw;
      end
      default: begin
        magnitude = raw;
        radix     = 64'd16;
      end
    endcase
    // Peel digits off the low end and prepend them.
    digits = 0;
    do begin
      digit     = 4'(magnitude % radix);
      magnitude = magnitude / radix;
      glyph     = (digit < 4'd10) ? CHAR_ZERO + {4'd0, digit}
                                  : CHAR_A + {4'd0, digit - 4'd10};
      text      = $sformatf("%c%s", glyph, text);
      digits++;
    end while (magnitude != 64'd0 && digits < NUM_DIGITS);
    if (negative) begin
      text = $sformatf("%c%s", CHAR_MINUS, text);
    end
    return text;
  endfunction

  task automatic add_case(input op_t op, input logic [63:0] value, input string text);
    format_case_t row;
    row.op    = op;
    row.value = value;
    row.text  = text;
    directed_cases.push_back(row);
  endtask

  // Offer one number, wait for it to be taken and queue its characters.
  task automatic send_word(input op_t op, input logic [63:0] value, input string text,
                           input bit gaps_allowed);
    string      chars;
    char_word_t item;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      if (gaps_allowed) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    chars = (text.len() != 0) ? text : render_number(op, value);
    for (int k = 0; k < chars.len(); k++) begin
      item.character = chars[k];
      item.last      = (k == chars.len() - 1);
      expected_chars.push_back(item);
    end
  endtask

  // Stimulus: directed table, then random numbers, then drain and report.
  initial begin : stimulus
    op_t         op;
    logic [63:0] value;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    add_case(OP_S32,   64'h0000_0000_0000_0000, "0");
    add_case(OP_U32,   64'h0000_0000_0000_0000, "0");
    add_case(OP_S64,   64'h0000_0000_0000_0000, "0");
    add_case(OP_HEX64, 64'h0000_0000_0000_0000, "0");
    add_case(OP_S32,   64'h0000_0000_7FFF_FFFF, "2147483647");
    add_case(OP_S32,   64'h0000_0000_8000_0000, "-2147483648");
    add_case(OP_S32,   64'h0000_0000_FFFF_FFFF, "-1");
    add_case(OP_U32,   64'h0000_0000_FFFF_FFFF, "4294967295");
    add_case(OP_U32,   64'h0000_0000_8000_0000, "2147483648");
    add_case(OP_S64,   64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807");
    add_case(OP_S64,   64'h8000_0000_0000_0000, "-9223372036854775808");
    add_case(OP_S64,   64'hFFFF_FFFF_FFFF_FFFF, "-1");
    add_case(OP_HEX64, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff");
    add_case(OP_HEX64, 64'h8000_0000_0000_0000, "8000000000000000");
    add_case(OP_S32,   64'hDEAD_BEEF_0000_0000, "0");
    add_case(OP_U32,   64'hFFFF_FFFF_0000_002A, "42");
    add_case(OP_HEX64, 64'h0123_4567_89AB_CDEF, "123456789abcdef");
    add_case(OP_HEX64, 64'h0000_0000_0000_000A, "a");
    add_case(OP_U32,   64'h0000_0000_3B9A_CA00, "1000000000");
    add_case(OP_S32,   64'hFFFF_FFFF_FFFF_FF85, "");
    add_case(OP_S32,   64'h1234_5678_8000_0001, "");
    add_case(OP_S64,   64'h0000_0000_0000_0009, "");
    add_case(OP_S64,   64'hFFFF_FFFF_FFFF_FFF6, "");
    add_case(OP_HEX64, 64'h0000_0000_0000_00F0, "");
    foreach (directed_cases[i]) begin
      send_word(directed_cases[i].op, directed_cases[i].value, directed_cases[i].text, 1'b1);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Long output stall while the input keeps being offered back to back.
      if (i == HOLD_WORD) begin
        hold_requests++;
      end
      // Let the block run completely dry once.
      if (i == PAUSE_WORD) begin
        s_tvalid   <= 1'b0;
        burst_left = 1;
        do @(posedge clk); while (expected_chars.size() != 0);
      end
      op = op_t'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(0, 20));
        2: value = -64'($urandom_range(1, 1000));
        3: begin
          value = 64'd1 << $urandom_range(0, 63);
          if ($urandom_range(0, 1) == 1) begin
            value = value - 64'd1;
          end
        end
        4: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        default: value = {($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0, 32'($urandom)};
      endcase
      send_word(op, value, "", (i < HOLD_WORD) || (i >= HOLD_END));
    end
    s_tvalid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_core_tb: done, clean");
    end else begin
      $display("integer_to_ascii_formatter_core_tb: done, errors");
    end
    $finish;
  end

  // Receiver: phases of steady acceptance and choppy stalls, plus the long hold.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_started < hold_requests) begin
      holds_started++;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        choppy    = ($urandom_range(0, 1) == 1);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (!choppy) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare every accepted output word with the oldest expected character.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        $error("character: expected none, actual %h", m_tdata);
        error_count++;
      end else begin
        got_char = expected_chars.pop_front();
        if (m_tdata !== got_char.character) begin
          $error("character: expected %h, actual %h", got_char.character, m_tdata);
          error_count++;
        end
        if (m_tlast !== got_char.last) begin
          $error("last: expected %b, actual %b", got_char.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_to_ascii_formatter_core_tb: done, errors");
      $finish;
    end
  end

endmodule
